// ----- rtl/gcd_pkg.sv -----
// Shared constants and elaboration-time helpers for the great-circle distance block.
package gcd_pkg;

    // Default number of CORDIC iterations for rotation and vectoring.
    localparam int CORDIC_STEPS = 32;
    // Square-root cells, one per result bit.
    localparam int SQRT_BITS = 64;

    // Angle units are 1e-7 degree.
    localparam logic [32:0] TURN_UNITS         = 33'd3600000000;
    localparam logic [32:0] HALF_TURN_UNITS    = 33'd1800000000;
    localparam logic [30:0] HALF_TURN_NARROW   = 31'd1800000000;
    localparam logic [30:0] QUARTER_TURN_UNITS = 31'd900000000;

    // pi * 2^61 / 1.8e9 as integer part and 32-bit fraction.
    localparam logic [31:0] RAD_INT  = 32'd4024455254;
    localparam logic [30:0] RAD_FRAC = 31'd2092896623;

    localparam logic signed [63:0] INV_GAIN_Q62   = 64'sd2800459870029452961;
    localparam logic signed [63:0] QUARTER_PI_Q61 = 64'sh1921FB54442D1846;
    localparam logic [63:0]        RADIUS_MM      = 64'd6371000000;
    localparam logic [127:0]       ONE_Q124       = 128'd1 << 124;
    localparam logic [63:0]        ONE_Q62        = 64'd1 << 62;

    // Shift-and-subtract quotient, evaluated at elaboration only.
    function automatic logic [63:0] udiv_const(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q61: pi/4 for the first step, else the truncated series.
    function automatic logic signed [63:0] atan_q61(input int unsigned i);
        logic signed [63:0] sum;
        logic [63:0]        term;
        int unsigned        e;
        sum = '0;
        if (i == 0) begin
            return QUARTER_PI_Q61;
        end
        for (int unsigned k = 0; k < 62; k++) begin
            e = i * (2 * k + 1);
            if (e <= 61) begin
                term = udiv_const(64'd1 << (61 - e), 64'(2 * k + 1));
                sum  = k[0] ? sum - $signed(term) : sum + $signed(term);
            end
        end
        return sum;
    endfunction

endpackage

// ----- rtl/gcd_cordic_cell.sv -----
// One CORDIC iteration cell, rotation or vectoring mode, registered outputs.
module gcd_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic signed [63:0] i_z,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y,
    output logic signed [63:0] o_z
);

    localparam logic signed [63:0] ANGLE = gcd_pkg::atan_q61(STEP);

    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic               ccw;
    logic signed [63:0] r_x;
    logic signed [63:0] r_y;
    logic signed [63:0] r_z;

    assign xs  = i_x >>> STEP;
    assign ys  = i_y >>> STEP;
    // rotation drives z toward zero, vectoring drives y toward zero
    assign ccw = VECTOR ? i_y[63] : !i_z[63];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (ccw) begin
                r_x <= i_x - ys;
                r_y <= i_y + xs;
                r_z <= i_z - ANGLE;
            end else begin
                r_x <= i_x + ys;
                r_y <= i_y - xs;
                r_z <= i_z + ANGLE;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ----- rtl/gcd_sqrt_cell.sv -----
// One bit of a restoring integer square root, registered outputs.
module gcd_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [127:0] i_rem,
    input  logic [63:0]  i_root,
    output logic [127:0] o_rem,
    output logic [63:0]  o_root
);

    localparam logic [127:0] SQ = 128'd1 << (2 * BIT);

    logic [127:0] trial;
    logic [127:0] r_rem;
    logic [63:0]  r_root;

    // (root + 2^bit)^2 - root^2
    assign trial = ({64'd0, i_root} << (BIT + 1)) + SQ;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_rem >= trial) begin
                r_rem  <= i_rem - trial;
                r_root <= i_root | (64'd1 << BIT);
            end else begin
                r_rem  <= i_rem;
                r_root <= i_root;
            end
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ----- rtl/gcd_mul.sv -----
// Unsigned 64x64 multiplier in three stages of 32x32 partial products.
module gcd_mul (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_p
);

    logic [63:0]  r_p00;
    logic [63:0]  r_p01;
    logic [63:0]  r_p10;
    logic [63:0]  r_p11;
    logic [63:0]  r_lo;
    logic [63:0]  r_hi;
    logic [64:0]  r_mid;
    logic [127:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
            r_p01 <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
            r_p10 <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
            r_p11 <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
            r_lo  <= r_p00;
            r_hi  <= r_p11;
            r_mid <= 65'(r_p01) + 65'(r_p10);
            r_p   <= {r_hi, r_lo} + ({63'd0, r_mid} << 32);
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/great_circle_distance.sv -----
// Top level: pipelined haversine great-circle distance between two positions.
//
// Input channel: i_valid / o_stall carry one request of two positions, each a
// latitude and longitude in signed 1e-7 degree. A request is taken at a clock
// edge with i_valid high and o_stall low. Output channel: o_valid / i_stall
// carry o_distance_mm, the distance in whole millimetres on a 6371 km sphere.
//
// Throughput: one request per cycle while o_stall is low. From acceptance to o_valid
// a request passes the chain of cells: four rotation lanes of CORDIC_STEPS cells,
// four 64x64 multipliers of three stages each (the last two side by side), two
// lanes of 64 square-root cells, CORDIC_STEPS vectoring cells and a final radius
// multiply.
//
// The whole pipe advances together. When the receiver stalls, the result holds
// in the output register and the next one drops into a one-entry skid buffer;
// only while the skid buffer is full is o_stall high and the pipe frozen.
// Reset (synchronous, active low) empties the pipe, the output register and
// the skid buffer; no result is shown until a new request has gone through.
module great_circle_distance #(
    parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [30:0] i_first_latitude,
    input  logic signed [31:0] i_first_longitude,
    input  logic signed [30:0] i_second_latitude,
    input  logic signed [31:0] i_second_longitude,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [34:0] o_distance_mm
);

    localparam int N     = CORDIC_STEPS;
    localparam int NSQ   = gcd_pkg::SQRT_BITS;
    localparam int DEPTH = 2 * N + 86;

    // Reduce an angle modulo a full turn and return its magnitude.
    function automatic logic [30:0] fold_turn(input logic signed [32:0] d);
        logic [32:0] m;
        m = d[32] ? 33'(-d) : 33'(d);
        if (m >= gcd_pkg::TURN_UNITS) begin
            m = m - gcd_pkg::TURN_UNITS;
        end
        if (m > gcd_pkg::HALF_TURN_UNITS) begin
            m = gcd_pkg::TURN_UNITS - m;
        end
        return m[30:0];
    endfunction

    // Magnitude of a Q62 product, saturated at one.
    function automatic logic [63:0] sat_q62(input logic [127:0] p);
        logic [63:0] r;
        r = p[125:62];
        if (r > gcd_pkg::ONE_Q62) begin
            r = gcd_pkg::ONE_Q62;
        end
        return r;
    endfunction

    logic en;
    logic [DEPTH-1:0] r_v;

    // ---------------------------------------------------------------
    // Angle preparation. Lanes: 0 half latitude difference, 1 half
    // longitude difference, 2 first latitude, 3 second latitude.
    // ---------------------------------------------------------------
    logic signed [32:0] dl [4];
    logic [30:0] r_ang [4];
    logic [30:0] r_qa  [4];
    logic [62:0] r_pi  [4];
    logic [61:0] r_pf  [4];
    logic signed [63:0] r_z0 [4];
    logic [1:0]  r_negl [N+3];

    assign dl[0] = 33'(i_second_latitude) - 33'(i_first_latitude);
    assign dl[1] = 33'(i_second_longitude) - 33'(i_first_longitude);
    assign dl[2] = 33'(i_first_latitude);
    assign dl[3] = 33'(i_second_latitude);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                r_ang[l] <= fold_turn(dl[l]);
                r_pi[l]  <= 63'(r_qa[l]) * 63'(gcd_pkg::RAD_INT);
                r_pf[l]  <= 62'(r_qa[l]) * 62'(gcd_pkg::RAD_FRAC);
            end
            // sin lanes take the angle as is
            r_qa[0] <= r_ang[0];
            r_qa[1] <= r_ang[1];
            // cos lanes fold beyond a quarter turn: cos(180 - x) = -cos x
            for (int l = 2; l < 4; l++) begin
                if (r_ang[l] > gcd_pkg::QUARTER_TURN_UNITS) begin
                    r_qa[l]        <= gcd_pkg::HALF_TURN_NARROW - r_ang[l];
                    r_negl[0][l-2] <= 1'b1;
                end else begin
                    r_qa[l]        <= r_ang[l];
                    r_negl[0][l-2] <= 1'b0;
                end
            end
            for (int l = 0; l < 4; l++) begin
                if (l < 2) begin
                    r_z0[l] <= {2'b00, 62'((r_pi[l] + 63'(r_pf[l][61:32])) >> 1)};
                end else begin
                    r_z0[l] <= {1'b0, r_pi[l] + 63'(r_pf[l][61:32])};
                end
            end
            // carry the cos sign flags alongside the rotation cells
            for (int k = 1; k < N + 3; k++) begin
                r_negl[k] <= r_negl[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Rotation lanes
    // ---------------------------------------------------------------
    logic signed [63:0] rx [4][N+1];
    logic signed [63:0] ry [4][N+1];
    logic signed [63:0] rz [4][N+1];

    for (genvar l = 0; l < 4; l++) begin : g_rot_lane
        assign rx[l][0] = gcd_pkg::INV_GAIN_Q62;
        assign ry[l][0] = '0;
        assign rz[l][0] = r_z0[l];
        for (genvar k = 0; k < N; k++) begin : g_cell
            gcd_cordic_cell #(
                .STEP   (k),
                .VECTOR (1'b0)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_x   (rx[l][k]),
                .i_y   (ry[l][k]),
                .i_z   (rz[l][k]),
                .o_x   (rx[l][k+1]),
                .o_y   (ry[l][k+1]),
                .o_z   (rz[l][k+1])
            );
        end
    end

    // ---------------------------------------------------------------
    // Magnitudes and signs, then cos(lat1)*cos(lat2)
    // ---------------------------------------------------------------
    logic signed [63:0] s1;
    logic signed [63:0] so;
    logic signed [63:0] c1;
    logic signed [63:0] c2;
    logic               c1_neg;
    logic               c2_neg;
    logic [63:0] r_s1m;
    logic [63:0] r_som;
    logic [63:0] r_c1m;
    logic [63:0] r_c2m;
    logic        r_psg;

    assign s1 = ry[0][N];
    assign so = ry[1][N];
    assign c1 = rx[2][N];
    assign c2 = rx[3][N];
    assign c1_neg = r_negl[N+2][0] ? (c1 > 64'sd0) : c1[63];
    assign c2_neg = r_negl[N+2][1] ? (c2 > 64'sd0) : c2[63];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1m <= s1[63] ? 64'(-s1) : 64'(s1);
            r_som <= so[63] ? 64'(-so) : 64'(so);
            r_c1m <= c1[63] ? 64'(-c1) : 64'(c1);
            r_c2m <= c2[63] ? 64'(-c2) : 64'(c2);
            r_psg <= c1_neg ^ c2_neg;
        end
    end

    logic [127:0] prod_p;
    logic [63:0]  r_d1_som [3];
    logic [63:0]  r_d1_s1m [3];
    logic         r_d1_psg [3];
    logic [63:0]  r_pmag;
    logic         r_pneg;
    logic [63:0]  r_p_som;
    logic [63:0]  r_p_s1m;

    gcd_mul u_mul_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_c1m),
        .i_b   (r_c2m),
        .o_p   (prod_p)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_som[0] <= r_som;
            r_d1_s1m[0] <= r_s1m;
            r_d1_psg[0] <= r_psg;
            for (int k = 1; k < 3; k++) begin
                r_d1_som[k] <= r_d1_som[k-1];
                r_d1_s1m[k] <= r_d1_s1m[k-1];
                r_d1_psg[k] <= r_d1_psg[k-1];
            end
            r_pmag  <= sat_q62(prod_p);
            r_pneg  <= r_d1_psg[2] && (sat_q62(prod_p) != '0);
            r_p_som <= r_d1_som[2];
            r_p_s1m <= r_d1_s1m[2];
        end
    end

    // ---------------------------------------------------------------
    // w = p * |sin(dlon/2)|
    // ---------------------------------------------------------------
    logic [127:0] prod_w;
    logic [63:0]  r_d2_som [3];
    logic [63:0]  r_d2_s1m [3];
    logic         r_d2_neg [3];
    logic [63:0]  r_wmag;
    logic         r_wneg;
    logic [63:0]  r_w_som;
    logic [63:0]  r_w_s1m;

    gcd_mul u_mul_w (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_pmag),
        .i_b   (r_p_som),
        .o_p   (prod_w)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2_som[0] <= r_p_som;
            r_d2_s1m[0] <= r_p_s1m;
            r_d2_neg[0] <= r_pneg;
            for (int k = 1; k < 3; k++) begin
                r_d2_som[k] <= r_d2_som[k-1];
                r_d2_s1m[k] <= r_d2_s1m[k-1];
                r_d2_neg[k] <= r_d2_neg[k-1];
            end
            r_wmag  <= sat_q62(prod_w);
            r_wneg  <= r_d2_neg[2] && (sat_q62(prod_w) != '0);
            r_w_som <= r_d2_som[2];
            r_w_s1m <= r_d2_s1m[2];
        end
    end

    // ---------------------------------------------------------------
    // a = sin^2(dlat/2) + w*|sin(dlon/2)| in Q124, clamped to [0,1]
    // ---------------------------------------------------------------
    logic [127:0] prod_t;
    logic [127:0] prod_a;
    logic         r_d3_neg [3];
    logic [127:0] r_sum;
    logic [127:0] r_clamp;
    logic [127:0] r_qa_sq;
    logic [127:0] r_qb_sq;

    gcd_mul u_mul_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_wmag),
        .i_b   (r_w_som),
        .o_p   (prod_t)
    );

    gcd_mul u_mul_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_w_s1m),
        .i_b   (r_w_s1m),
        .o_p   (prod_a)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3_neg[0] <= r_wneg;
            for (int k = 1; k < 3; k++) begin
                r_d3_neg[k] <= r_d3_neg[k-1];
            end
            if (!r_d3_neg[2]) begin
                r_sum <= prod_a + prod_t;
            end else if (prod_a < prod_t) begin
                r_sum <= '0;
            end else begin
                r_sum <= prod_a - prod_t;
            end
            r_clamp <= (r_sum > gcd_pkg::ONE_Q124) ? gcd_pkg::ONE_Q124 : r_sum;
            r_qa_sq <= r_clamp;
            r_qb_sq <= gcd_pkg::ONE_Q124 - r_clamp;
        end
    end

    // ---------------------------------------------------------------
    // Square roots of a and 1-a
    // ---------------------------------------------------------------
    logic [127:0] sq_rem  [2][NSQ+1];
    logic [63:0]  sq_root [2][NSQ+1];

    assign sq_rem[0][0]  = r_qa_sq;
    assign sq_rem[1][0]  = r_qb_sq;
    assign sq_root[0][0] = '0;
    assign sq_root[1][0] = '0;

    for (genvar l = 0; l < 2; l++) begin : g_sqrt_lane
        for (genvar j = 0; j < NSQ; j++) begin : g_cell
            gcd_sqrt_cell #(
                .BIT (NSQ - 1 - j)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_rem  (sq_rem[l][j]),
                .i_root (sq_root[l][j]),
                .o_rem  (sq_rem[l][j+1]),
                .o_root (sq_root[l][j+1])
            );
        end
    end

    // ---------------------------------------------------------------
    // Vectoring: z = atan2(sqrt(a), sqrt(1-a)) in Q61
    // ---------------------------------------------------------------
    logic signed [63:0] vx [N+1];
    logic signed [63:0] vy [N+1];
    logic signed [63:0] vz [N+1];

    assign vy[0] = $signed(sq_root[0][NSQ] >> 1);
    assign vx[0] = $signed(sq_root[1][NSQ] >> 1);
    assign vz[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_vec
        gcd_cordic_cell #(
            .STEP   (k),
            .VECTOR (1'b1)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (vx[k]),
            .i_y   (vy[k]),
            .i_z   (vz[k]),
            .o_x   (vx[k+1]),
            .o_y   (vy[k+1]),
            .o_z   (vz[k+1])
        );
    end

    // ---------------------------------------------------------------
    // Distance = z * radius / 2^60, negative angle clamped to zero
    // ---------------------------------------------------------------
    logic [63:0]  z_pos;
    logic [127:0] prod_d;

    assign z_pos = vz[N][63] ? '0 : 64'(vz[N]);

    gcd_mul u_mul_d (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (z_pos),
        .i_b   (gcd_pkg::RADIUS_MM),
        .o_p   (prod_d)
    );

    // ---------------------------------------------------------------
    // Valid line, output register and skid buffer
    // ---------------------------------------------------------------
    logic        out_load;
    logic        r_ov;
    logic [34:0] r_out;
    logic        r_skid_full;
    logic [34:0] r_skid;

    // advance the whole pipe unless a result is parked in the skid buffer
    assign en       = !r_skid_full;
    assign out_load = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_ov        <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            if (en) begin
                r_v <= {r_v[DEPTH-2:0], i_valid};
            end
            if (r_skid_full) begin
                if (out_load) begin
                    r_ov        <= 1'b1;
                    r_skid_full <= 1'b0;
                end
            end else if (r_v[DEPTH-1]) begin
                if (out_load) begin
                    r_ov <= 1'b1;
                end else begin
                    r_skid_full <= 1'b1;
                end
            end else if (out_load) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (out_load) begin
                r_out <= r_skid;
            end
        end else if (out_load) begin
            r_out <= prod_d[94:60];
        end else begin
            r_skid <= prod_d[94:60];
        end
    end

    assign o_stall       = r_skid_full;
    assign o_valid       = r_ov;
    assign o_distance_mm = r_out;

endmodule

// ----- tb/sv/tb_great_circle_distance.sv -----
// Self-checking testbench for the pipelined great-circle distance block.
`timescale 1ns / 1ps

module tb_great_circle_distance;

    localparam int STEPS       = gcd_pkg::CORDIC_STEPS;
    localparam int LATENCY     = 2 * STEPS + 86;
    localparam int IDLE_LIMIT  = 20000;
    localparam int RANDOM_REQS = 1330;
    localparam int LONG_HOLD   = 400;

    // one request: two positions in 1e-7 degree
    typedef struct packed {
        logic signed [30:0] lat1;
        logic signed [31:0] lon1;
        logic signed [30:0] lat2;
        logic signed [31:0] lon2;
    } position_pair_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [30:0] i_first_latitude = '0;
    logic signed [31:0] i_first_longitude = '0;
    logic signed [30:0] i_second_latitude = '0;
    logic signed [31:0] i_second_longitude = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic        [34:0] o_distance_mm;

    position_pair_t pending_pairs[$];
    logic [34:0]    expected_distances[$];

    int requests_sent;
    int distances_checked;
    int mismatch_count;
    int input_stall_cycles;
    bit long_hold_done;

    great_circle_distance u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_first_latitude   (i_first_latitude),
        .i_first_longitude  (i_first_longitude),
        .i_second_latitude  (i_second_latitude),
        .i_second_longitude (i_second_longitude),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_distance_mm      (o_distance_mm)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Distance predictor, bit exact to the fixed-point haversine datapath.
    // ---------------------------------------------------------------------

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // atan(2^-i) in Q61: pi/4 for step 0, else alternating series truncated
    function automatic logic signed [63:0] arctan_step(input int i);
        logic signed [63:0] acc;
        logic [63:0]        term;
        int                 e;
        if (i == 0) begin
            return gcd_pkg::QUARTER_PI_Q61;
        end
        acc = '0;
        for (int k = 0; k < 62; k++) begin
            e = i * (2 * k + 1);
            if (e <= 61) begin
                term = (64'd1 << (61 - e)) / 64'(2 * k + 1);
                acc  = k[0] ? acc - $signed(term) : acc + $signed(term);
            end
        end
        return acc;
    endfunction

    // reduce an angle difference modulo a full turn, keep its magnitude
    function automatic logic [63:0] fold_angle(input logic signed [63:0] d);
        logic signed [63:0] r;
        r = d % 64'sd3600000000;
        if (r > 64'sd1800000000) r = r - 64'sd3600000000;
        if (r < -64'sd1800000000) r = r + 64'sd3600000000;
        return abs64(r);
    endfunction

    function automatic logic signed [63:0] to_radians(input logic [63:0] a);
        return $signed(a * 64'(gcd_pkg::RAD_INT) + ((a * 64'(gcd_pkg::RAD_FRAC)) >> 32));
    endfunction

    function automatic void rotate_angle(input logic signed [63:0] angle,
                                         output logic signed [63:0] cos_q62,
                                         output logic signed [63:0] sin_q62);
        logic signed [63:0] x, y, z, nx, t;
        x = gcd_pkg::INV_GAIN_Q62;
        y = '0;
        z = angle;
        for (int i = 0; i < STEPS; i++) begin
            t = arctan_step(i);
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - t;
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + t;
            end
            x = nx;
        end
        cos_q62 = x;
        sin_q62 = y;
    endfunction

    function automatic logic signed [63:0] half_sine(input logic signed [63:0] d);
        logic signed [63:0] c, s;
        rotate_angle(to_radians(fold_angle(d)) >>> 1, c, s);
        return s;
    endfunction

    // latitudes past a quarter turn fold through cos(180 - x) = -cos(x)
    function automatic logic signed [63:0] full_cosine(input logic signed [63:0] d);
        logic [63:0]        a;
        logic signed [63:0] c, s;
        bit                 flip;
        a    = fold_angle(d);
        flip = 1'b0;
        if (a > 64'd900000000) begin
            a    = 64'd1800000000 - a;
            flip = 1'b1;
        end
        rotate_angle(to_radians(a), c, s);
        return flip ? -c : c;
    endfunction

    function automatic logic signed [63:0] mul_q62(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [127:0] p;
        logic [63:0]  r;
        p = 128'(abs64(a)) * 128'(abs64(b));
        r = p[125:62];
        if (r > gcd_pkg::ONE_Q62) r = gcd_pkg::ONE_Q62;
        return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0] r, t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic [34:0] predict_distance(input position_pair_t pp);
        logic signed [63:0] lat1, lon1, lat2, lon2;
        logic signed [63:0] s_lat, s_lon, cos_prod, w, x, y, z, nx, t;
        logic [127:0]       hav, cross_term, rest, dist_prod;
        lat1 = pp.lat1; lon1 = pp.lon1; lat2 = pp.lat2; lon2 = pp.lon2;
        s_lat    = half_sine(lat2 - lat1);
        s_lon    = half_sine(lon2 - lon1);
        cos_prod = mul_q62(full_cosine(lat1), full_cosine(lat2));
        w        = mul_q62(cos_prod, $signed(abs64(s_lon)));
        hav        = 128'(abs64(s_lat)) * 128'(abs64(s_lat));
        cross_term = 128'(abs64(w)) * 128'(abs64(s_lon));
        // a sits in Q124; clamp to [0,1]
        if (w >= 0) hav = hav + cross_term;
        else if (hav < cross_term) hav = '0;
        else hav = hav - cross_term;
        if (hav > gcd_pkg::ONE_Q124) hav = gcd_pkg::ONE_Q124;
        rest = gcd_pkg::ONE_Q124 - hav;
        y = $signed(floor_sqrt(hav) >> 1);
        x = $signed(floor_sqrt(rest) >> 1);
        z = '0;
        for (int i = 0; i < STEPS; i++) begin
            t = arctan_step(i);
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + t;
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - t;
            end
            x = nx;
        end
        if (z < 0) z = '0;
        dist_prod = 128'(z) * 128'(gcd_pkg::RADIUS_MM);
        return dist_prod[94:60];
    endfunction

    // ---------------------------------------------------------------------
    // Request generation
    // ---------------------------------------------------------------------

    function automatic position_pair_t make_pair(input longint lat1, input longint lon1,
                                                 input longint lat2, input longint lon2);
        position_pair_t pp;
        pp.lat1 = lat1[30:0]; pp.lon1 = lon1[31:0];
        pp.lat2 = lat2[30:0]; pp.lon2 = lon2[31:0];
        return pp;
    endfunction

    function automatic longint random_lat();
        return longint'($urandom_range(1800000000, 0)) - 900000000;
    endfunction

    function automatic longint random_lon();
        return longint'($urandom_range(3600000000, 0)) - 1800000000;
    endfunction

    function automatic position_pair_t random_pair();
        position_pair_t pp;
        longint         lat, lon;
        int unsigned    kind;
        kind = $urandom_range(99, 0);
        if (kind < 55) begin
            // ordinary positions anywhere on the globe
            pp = make_pair(random_lat(), random_lon(), random_lat(), random_lon());
        end else if (kind < 75) begin
            // close neighbors: small differences around a random point
            lat = random_lat();
            lon = random_lon();
            pp  = make_pair(lat, lon, lat + longint'($urandom_range(2000, 0)) - 1000,
                            lon + longint'($urandom_range(2000, 0)) - 1000);
        end else if (kind < 85) begin
            // near antipodes
            lat = random_lat();
            lon = random_lon();
            pp  = make_pair(lat, lon, -lat + longint'($urandom_range(200, 0)) - 100,
                            lon + 1800000000 + longint'($urandom_range(200, 0)) - 100);
        end else begin
            // raw bit patterns, ranges unchecked
            pp.lat1 = 31'($urandom); pp.lon1 = $urandom;
            pp.lat2 = 31'($urandom); pp.lon2 = $urandom;
        end
        return pp;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // ---------------------------------------------------------------------
    // Driver: present pending requests, hold while stalled
    // ---------------------------------------------------------------------

    int send_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            // request taken at this edge: record its distance
            if (i_valid && !o_stall) begin
                expected_distances.push_back(predict_distance({i_first_latitude,
                    i_first_longitude, i_second_latitude, i_second_longitude}));
                requests_sent++;
            end
            // a stalled request stays exactly as it is
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    position_pair_t pp;
                    pp = pending_pairs.pop_front();
                    i_first_latitude   <= pp.lat1;
                    i_first_longitude  <= pp.lon1;
                    i_second_latitude  <= pp.lat2;
                    i_second_longitude <= pp.lon2;
                    i_valid            <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (o_stall) input_stall_cycles++;
        end
    end

    // ---------------------------------------------------------------------
    // Receiver stall pattern, with one long hold to back up the pipe
    // ---------------------------------------------------------------------

    int hold_count;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            hold_count = 0;
        end else if (hold_count > 0) begin
            hold_count--;
        end else if (!long_hold_done && distances_checked >= 500) begin
            // keep stall high long enough for the skid buffer to fill
            long_hold_done = 1'b1;
            i_stall    <= 1'b1;
            hold_count = LONG_HOLD;
        end else begin
            int unsigned r;
            r = $urandom_range(99, 0);
            if (r < 50) begin
                i_stall    <= 1'b0;
                hold_count = $urandom_range(30, 0);
            end else if (r < 93) begin
                i_stall    <= 1'b1;
                hold_count = $urandom_range(3, 0);
            end else begin
                i_stall    <= 1'b1;
                hold_count = $urandom_range(40, 10);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: compare each accepted distance against the oldest prediction
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_distances.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected distance, expected none, actual %0d",
                         $realtime, o_distance_mm);
            end else begin
                logic [34:0] want;
                want = expected_distances.pop_front();
                if (o_distance_mm !== want) begin
                    mismatch_count++;
                    $display("%0t: distance_mm mismatch, expected %0d, actual %0d",
                             $realtime, want, o_distance_mm);
                end
            end
            distances_checked++;
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: stop when nothing moves on either side for too long
    // ---------------------------------------------------------------------

    int idle_cycles;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d requests sent, %0d distances checked",
                     requests_sent, distances_checked);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------------

    initial begin
        // identical points, both zero and at extremes
        pending_pairs.push_back(make_pair(0, 0, 0, 0));
        pending_pairs.push_back(make_pair(900000000, 1800000000, 900000000, 1800000000));
        // pole to pole, equator antipodes, one point at -180 and 180, quarter turn
        pending_pairs.push_back(make_pair(900000000, 0, -900000000, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 1800000000));
        pending_pairs.push_back(make_pair(0, -1800000000, 0, 1800000000));
        pending_pairs.push_back(make_pair(0, 0, 0, 900000000));
        pending_pairs.push_back(make_pair(0, 0, 900000000, 0));
        // longitude difference past a half turn wraps around
        pending_pairs.push_back(make_pair(100000000, -1700000000, 100000000, 1700000000));
        pending_pairs.push_back(make_pair(0, -1800000000, 0, 1799999999));
        // latitudes beyond a quarter turn fold through the pole
        pending_pairs.push_back(make_pair(1000000000, 0, 0, 0));
        pending_pairs.push_back(make_pair(-1073741824, 0, 1073741823, 500000000));
        // raw field extremes, ranges unchecked, then one unit below zero on both axes
        pending_pairs.push_back(make_pair(-1073741824, -2147483648, 1073741823, 2147483647));
        pending_pairs.push_back(make_pair(1073741823, 2147483647, -1073741824, -2147483648));
        pending_pairs.push_back(make_pair(-1073741824, 2147483647, -1073741824, -2147483648));
        pending_pairs.push_back(make_pair(-1, -1, 0, 0));
        // tiny separations, one unit apart
        pending_pairs.push_back(make_pair(0, 0, 1, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 1));
        pending_pairs.push_back(make_pair(899999999, 0, 900000000, 0));
        // near antipodes where a rounds toward one
        pending_pairs.push_back(make_pair(450000000, 300000000, -450000000, -1500000000));
        pending_pairs.push_back(make_pair(1, 0, 0, 1800000000));
        for (int n = 0; n < RANDOM_REQS; n++) begin
            pending_pairs.push_back(random_pair());
        end

        // hold reset low, then release once
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_pairs.size() == 0 && !i_valid && expected_distances.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("run covered %0d requests with %0d distances checked and %0d mismatches",
                 requests_sent, distances_checked, mismatch_count);
        $display("input held off for %0d cycles, including one %0d-cycle output hold",
                 input_stall_cycles, LONG_HOLD);
        if (mismatch_count == 0 && expected_distances.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- great_circle_distance.f -----
rtl/gcd_pkg.sv
rtl/gcd_cordic_cell.sv
rtl/gcd_sqrt_cell.sv
rtl/gcd_mul.sv
rtl/great_circle_distance.sv
tb/sv/tb_great_circle_distance.sv
